// ----- design/srt_pkg.sv -----
// Shared types, codes and helpers of the prefix-sorted route table.
`timescale 1ns / 1ps
package srt_pkg;

  localparam int unsigned ROUTES_DEF = 16;
  localparam int unsigned PLEN_W     = 6;

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_LOOKUP = 3'd0;
  localparam mode_t MODE_ADD    = 3'd1;
  localparam mode_t MODE_DELETE = 3'd2;
  localparam mode_t MODE_CHANGE = 3'd3;
  localparam mode_t MODE_FLUSH  = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_EXISTS    = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [31:0] gateway_in;
    logic [7:0]  route_flags;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] gateway_out;
    logic [7:0]  match_flags;
  } rsp_t;

  typedef struct packed {
    logic [31:0]       net;
    logic [31:0]       mask;
    logic [31:0]       gateway;
    logic [7:0]        flags;
    logic [PLEN_W-1:0] plen;
  } entry_t;

  typedef enum logic [2:0] {
    ACT_HOLD,
    ACT_LOAD_NEW,
    ACT_FROM_PREV,
    ACT_FROM_NEXT,
    ACT_UPDATE
  } cell_act_e;

  typedef struct packed {
    cell_act_e act;
    logic      cmp_en;
    logic      valid;
  } cell_ctrl_t;

  typedef struct packed {
    logic hit;
    logic exact;
    logic ge;
  } cell_flags_t;

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + {3'd0, v[k]};
    end
    return n;
  endfunction

  function automatic logic [PLEN_W-1:0] popcount32(input logic [31:0] v);
    logic [4:0] lo;
    logic [4:0] hi;
    lo = {1'b0, popcount8(v[7:0])} + {1'b0, popcount8(v[15:8])};
    hi = {1'b0, popcount8(v[23:16])} + {1'b0, popcount8(v[31:24])};
    return {1'b0, lo} + {1'b0, hi};
  endfunction

endpackage

// ----- design/srt_stream_if.sv -----
// Valid/ready stream channel carrying one payload per transaction.
`timescale 1ns / 1ps
interface srt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- design/srt_cell.sv -----
// One route table cell: holds an entry, compares it and swaps with neighbors.
`timescale 1ns / 1ps
module srt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srt_pkg::cell_ctrl_t ctrl_i,
  input  srt_pkg::entry_t     req_entry_i,
  input  srt_pkg::entry_t     prev_entry_i,
  input  srt_pkg::entry_t     next_entry_i,
  output srt_pkg::entry_t     entry_o,
  output srt_pkg::cell_flags_t flags_o
);

  srt_pkg::entry_t      entry_q, entry_d;
  srt_pkg::cell_flags_t flags_q, flags_d;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.act)
      srt_pkg::ACT_HOLD:      entry_d = entry_q;
      srt_pkg::ACT_LOAD_NEW:  entry_d = req_entry_i;
      srt_pkg::ACT_FROM_PREV: entry_d = prev_entry_i;
      srt_pkg::ACT_FROM_NEXT: entry_d = next_entry_i;
      srt_pkg::ACT_UPDATE: begin
        entry_d.gateway = req_entry_i.gateway;
        entry_d.flags   = req_entry_i.flags;
      end
      default:                entry_d = entry_q;
    endcase
  end

  // req_entry_i.net carries the lookup address as well as the route network
  always_comb begin
    flags_d = flags_q;
    if (ctrl_i.cmp_en) begin
      flags_d.hit   = ctrl_i.valid &&
                      ((req_entry_i.net & entry_q.mask) == entry_q.net);
      flags_d.exact = ctrl_i.valid && (req_entry_i.net == entry_q.net) &&
                      (req_entry_i.mask == entry_q.mask);
      flags_d.ge    = ctrl_i.valid && (req_entry_i.plen >= entry_q.plen);
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  assign entry_o = entry_q;
  assign flags_o = flags_q;

endmodule

// ----- design/prefix_sorted_route_table.sv -----
// Each request passes a compare step in the cell row, then an apply step that shifts,
// writes or selects across the row; the response is registered by the apply step.
// A new request is accepted in the apply step of the previous one, not during its compare.
// A response waiting on the output holds the apply step and the next request's accept.
// Reset: asynchronous, active low; empties the table (route count zero), no clearing pass.
// Entry contents are not reset.
`timescale 1ns / 1ps
module prefix_sorted_route_table #(
  parameter int unsigned ROUTES = srt_pkg::ROUTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  srt_stream_if.sink   req_i,
  srt_stream_if.source rsp_o
);

  localparam int unsigned CW = $clog2(ROUTES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_e;

  state_e                    state_q;
  logic [CW-1:0]             count_q;
  logic                      rsp_valid_q;
  srt_pkg::rsp_t             rsp_q;
  srt_pkg::req_t             req_q;
  logic [srt_pkg::PLEN_W-1:0] plen_q;

  srt_pkg::entry_t      req_entry;
  srt_pkg::entry_t      cell_entry [ROUTES];
  srt_pkg::cell_flags_t cell_flags [ROUTES];
  srt_pkg::cell_ctrl_t  cell_ctrl  [ROUTES];

  logic [ROUTES-1:0] hit_vec, exact_vec, ge_vec, valid_vec, ge_ext, ge_prev;
  logic [ROUTES-1:0] first_hit, after_exact;
  logic              any_hit, any_exact, full;
  logic              apply_go, req_take;
  srt_pkg::rsp_t     rsp_d;
  logic [CW-1:0]     count_d;

  assign apply_go = (state_q == S_APPLY) && (!rsp_valid_q || rsp_o.ready);
  assign req_take = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE) || apply_go;

  assign req_entry.net     = req_q.addr;
  assign req_entry.mask    = req_q.mask;
  assign req_entry.gateway = req_q.gateway_in;
  assign req_entry.flags   = req_q.route_flags;
  assign req_entry.plen    = plen_q;

  for (genvar g = 0; g < ROUTES; g++) begin : g_cell
    srt_pkg::entry_t prev_entry, next_entry;
    if (g > 0) begin : g_prev
      assign prev_entry = cell_entry[g-1];
    end else begin : g_no_prev
      assign prev_entry = req_entry;
    end
    if (g < ROUTES - 1) begin : g_next
      assign next_entry = cell_entry[g+1];
    end else begin : g_no_next
      assign next_entry = req_entry;
    end

    srt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl[g]),
      .req_entry_i  (req_entry),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .entry_o      (cell_entry[g]),
      .flags_o      (cell_flags[g])
    );

    assign hit_vec[g]   = cell_flags[g].hit;
    assign exact_vec[g] = cell_flags[g].exact;
    assign ge_vec[g]    = cell_flags[g].ge;
    assign valid_vec[g] = (CW'(g) < count_q);
    // the first empty slot also takes an add when no prefix of equal or shorter length exists
    assign ge_ext[g]    = ge_vec[g] || (count_q == CW'(g));
  end

  assign any_hit     = |hit_vec;
  assign any_exact   = |exact_vec;
  assign full        = (count_q == CW'(ROUTES));
  assign first_hit   = hit_vec & (~hit_vec + ROUTES'(1));
  assign ge_prev     = ge_ext << 1;
  // cells at and below the deleted entry pull from the next one
  assign after_exact = ~(exact_vec - ROUTES'(1));

  always_comb begin
    for (int i = 0; i < ROUTES; i++) begin
      cell_ctrl[i].act    = srt_pkg::ACT_HOLD;
      cell_ctrl[i].cmp_en = (state_q == S_CMP);
      cell_ctrl[i].valid  = valid_vec[i];
      if (apply_go) begin
        case (req_q.mode)
          srt_pkg::MODE_ADD: begin
            if (!any_exact && !full) begin
              if (ge_prev[i]) begin
                cell_ctrl[i].act = srt_pkg::ACT_FROM_PREV;
              end else if (ge_ext[i]) begin
                cell_ctrl[i].act = srt_pkg::ACT_LOAD_NEW;
              end
            end
          end
          srt_pkg::MODE_DELETE: begin
            if (any_exact && after_exact[i] && i < ROUTES - 1) begin
              cell_ctrl[i].act = srt_pkg::ACT_FROM_NEXT;
            end
          end
          srt_pkg::MODE_CHANGE: begin
            if (exact_vec[i]) begin
              cell_ctrl[i].act = srt_pkg::ACT_UPDATE;
            end
          end
          default: cell_ctrl[i].act = srt_pkg::ACT_HOLD;
        endcase
      end
    end
  end

  always_comb begin
    rsp_d.status      = srt_pkg::ST_NOT_FOUND;
    rsp_d.gateway_out = '0;
    rsp_d.match_flags = '0;
    count_d           = count_q;
    case (req_q.mode)
      srt_pkg::MODE_LOOKUP: begin
        if (any_hit) begin
          rsp_d.status = srt_pkg::ST_OK;
        end
        for (int i = 0; i < ROUTES; i++) begin
          if (first_hit[i]) begin
            rsp_d.gateway_out = rsp_d.gateway_out | cell_entry[i].gateway;
            rsp_d.match_flags = rsp_d.match_flags | cell_entry[i].flags;
          end
        end
      end
      srt_pkg::MODE_ADD: begin
        if (any_exact) begin
          rsp_d.status = srt_pkg::ST_EXISTS;
        end else if (full) begin
          rsp_d.status = srt_pkg::ST_FULL;
        end else begin
          rsp_d.status = srt_pkg::ST_OK;
          count_d      = count_q + CW'(1);
        end
      end
      srt_pkg::MODE_DELETE: begin
        if (any_exact) begin
          rsp_d.status = srt_pkg::ST_OK;
          count_d      = count_q - CW'(1);
        end
      end
      srt_pkg::MODE_CHANGE: begin
        if (any_exact) begin
          rsp_d.status = srt_pkg::ST_OK;
        end
      end
      srt_pkg::MODE_FLUSH: begin
        rsp_d.status = srt_pkg::ST_OK;
        count_d      = '0;
      end
      default: rsp_d.status = srt_pkg::ST_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      req_q  <= req_i.payload;
      plen_q <= srt_pkg::popcount32(req_i.payload.mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      if (apply_go) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_take) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: state_q <= S_APPLY;
        S_APPLY: begin
          if (apply_go) begin
            rsp_q       <= rsp_d;
            count_q     <= count_d;
            state_q     <= req_take ? S_CMP : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

endmodule

// ----- tb/srt_route_checker.sv -----
// Route table scoreboard: mirrors the table state, predicts responses and compares them.
`timescale 1ns / 1ps
module srt_route_checker #(
  parameter int unsigned ROUTES = srt_pkg::ROUTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_ready_i,
  input  srt_pkg::req_t  req_i,
  input  logic           rsp_valid_i,
  input  logic           rsp_ready_i,
  input  srt_pkg::rsp_t  rsp_i,
  output int unsigned    pending_o,
  output int unsigned    fail_count_o
);

  srt_pkg::entry_t route_tbl [ROUTES];
  int unsigned     route_cnt;
  int unsigned     fail_cnt;
  srt_pkg::rsp_t   expected_rsp_q [$];

  // Index of the exact (net, mask) route, or route_cnt when there is none.
  function automatic int unsigned exact_index(input logic [31:0] net, input logic [31:0] msk);
    int unsigned idx;
    idx = route_cnt;
    for (int unsigned i = 0; i < route_cnt; i++) begin
      if (idx == route_cnt && route_tbl[i].net == net && route_tbl[i].mask == msk) begin
        idx = i;
      end
    end
    return idx;
  endfunction

  // Update the mirrored table with one request and return the response it must give.
  function automatic srt_pkg::rsp_t apply_request(input srt_pkg::req_t r);
    srt_pkg::rsp_t              rsp;
    int unsigned                idx;
    int unsigned                pos;
    logic [srt_pkg::PLEN_W-1:0] plen;
    logic                       hit;
    rsp.status      = srt_pkg::ST_NOT_FOUND;
    rsp.gateway_out = '0;
    rsp.match_flags = '0;
    case (r.mode)
      srt_pkg::MODE_LOOKUP: begin
        hit = 1'b0;
        for (int unsigned i = 0; i < route_cnt; i++) begin
          if (!hit && (r.addr & route_tbl[i].mask) == route_tbl[i].net) begin
            hit             = 1'b1;
            rsp.status      = srt_pkg::ST_OK;
            rsp.gateway_out = route_tbl[i].gateway;
            rsp.match_flags = route_tbl[i].flags;
          end
        end
      end
      srt_pkg::MODE_ADD: begin
        idx = exact_index(r.addr, r.mask);
        if (idx < route_cnt) begin
          rsp.status = srt_pkg::ST_EXISTS;
        end else if (route_cnt >= ROUTES) begin
          rsp.status = srt_pkg::ST_FULL;
        end else begin
          plen = srt_pkg::PLEN_W'($countones(r.mask));
          pos  = route_cnt;
          for (int unsigned i = 0; i < route_cnt; i++) begin
            if (pos == route_cnt && plen >= route_tbl[i].plen) begin
              pos = i;
            end
          end
          // Shift entries at and below the insertion point down by one.
          for (int unsigned i = route_cnt; i > pos; i--) begin
            route_tbl[i] = route_tbl[i-1];
          end
          route_tbl[pos].net     = r.addr;
          route_tbl[pos].mask    = r.mask;
          route_tbl[pos].gateway = r.gateway_in;
          route_tbl[pos].flags   = r.route_flags;
          route_tbl[pos].plen    = plen;
          route_cnt++;
          rsp.status = srt_pkg::ST_OK;
        end
      end
      srt_pkg::MODE_DELETE: begin
        idx = exact_index(r.addr, r.mask);
        if (idx < route_cnt) begin
          for (int unsigned i = idx; i + 1 < route_cnt; i++) begin
            route_tbl[i] = route_tbl[i+1];
          end
          route_cnt--;
          rsp.status = srt_pkg::ST_OK;
        end
      end
      srt_pkg::MODE_CHANGE: begin
        idx = exact_index(r.addr, r.mask);
        if (idx < route_cnt) begin
          route_tbl[idx].gateway = r.gateway_in;
          route_tbl[idx].flags   = r.route_flags;
          rsp.status = srt_pkg::ST_OK;
        end
      end
      srt_pkg::MODE_FLUSH: begin
        route_cnt  = 0;
        rsp.status = srt_pkg::ST_OK;
      end
      default: begin
        rsp.status = srt_pkg::ST_NOT_FOUND;
      end
    endcase
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    srt_pkg::rsp_t want;
    if (!rst_ni) begin
      expected_rsp_q.delete();
      route_cnt    = 0;
      fail_cnt     = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // Retire the response first: it always belongs to an older request.
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response with no request outstanding: status %0d gateway_out %h",
                 rsp_i.status, rsp_i.gateway_out);
          fail_cnt++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_i.status);
            fail_cnt++;
          end
          if (rsp_i.gateway_out !== want.gateway_out) begin
            $error("gateway_out: expected %h, got %h", want.gateway_out, rsp_i.gateway_out);
            fail_cnt++;
          end
          if (rsp_i.match_flags !== want.match_flags) begin
            $error("match_flags: expected %h, got %h", want.match_flags, rsp_i.match_flags);
            fail_cnt++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_rsp_q.push_back(apply_request(req_i));
      end
      pending_o    <= expected_rsp_q.size();
      fail_count_o <= fail_cnt;
    end
  end

endmodule

// ----- tb/tb_prefix_sorted_route_table.sv -----
// Top of the route table testbench: clock, reset, request and response traffic, verdict.
`timescale 1ns / 1ps
module tb_prefix_sorted_route_table;

  localparam int unsigned ROUTES       = srt_pkg::ROUTES_DEF;
  localparam int unsigned RANDOM_ITEMS = 725;
  localparam int unsigned POOL_SIZE    = 20;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam srt_pkg::mode_t MODE_SPARE_5 = 3'd5;
  localparam srt_pkg::mode_t MODE_SPARE_6 = 3'd6;
  localparam srt_pkg::mode_t MODE_SPARE_7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  bit          calm;
  int unsigned pending_cnt;
  int unsigned fail_cnt;
  int unsigned idle_cycles = 0;
  int unsigned rsp_stall;
  logic [31:0] pool_net  [POOL_SIZE];
  logic [31:0] pool_mask [POOL_SIZE];

  srt_stream_if #(.payload_t(srt_pkg::req_t)) req_if ();
  srt_stream_if #(.payload_t(srt_pkg::rsp_t)) rsp_if ();

  prefix_sorted_route_table #(.ROUTES(ROUTES)) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  srt_route_checker #(.ROUTES(ROUTES)) route_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_valid_i (req_if.valid),
    .req_ready_i (req_if.ready),
    .req_i       (req_if.payload),
    .rsp_valid_i (rsp_if.valid),
    .rsp_ready_i (rsp_if.ready),
    .rsp_i       (rsp_if.payload),
    .pending_o   (pending_cnt),
    .fail_count_o(fail_cnt)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none while calm.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic srt_pkg::req_t route_req(input srt_pkg::mode_t m, input logic [31:0] a,
                                              input logic [31:0] msk, input logic [31:0] gw,
                                              input logic [7:0] fl);
    srt_pkg::req_t r;
    r.mode        = m;
    r.addr        = a;
    r.mask        = msk;
    r.gateway_in  = gw;
    r.route_flags = fl;
    return r;
  endfunction

  // Keep valid high across back-to-back transactions; drop it only for a gap.
  task automatic send_req(input srt_pkg::req_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  task automatic drain_responses();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  // Response side: random stalls, released entirely while calm.
  initial begin
    rsp_stall = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_stall > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_stall--;
      end else if ($urandom_range(0, 3) == 0) begin
        rsp_stall = pick_gap();
        rsp_if.ready <= (rsp_stall == 0);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    srt_pkg::req_t r;
    int unsigned   sent;
    int unsigned   ep_len;
    int unsigned   plen;
    int unsigned   p;
    int unsigned   roll;
    int unsigned   w_add;
    int unsigned   w_look;
    int unsigned   w_del;
    int unsigned   w_chg;
    int unsigned   w_flush;
    logic [31:0]   base;
    logic [31:0]   addr;

    calm = 1'b0;
    rst_n          <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, spare modes, default and host routes, duplicates, shadowed prefixes.
    send_req(route_req(srt_pkg::MODE_FLUSH,  32'h0000_0000, 32'h0000_0000, 32'h0, 8'h00));
    send_req(route_req(srt_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000, 32'h0, 8'h00));
    send_req(route_req(srt_pkg::MODE_DELETE, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 8'h00));
    send_req(route_req(srt_pkg::MODE_CHANGE, 32'h0A00_0000, 32'hFF00_0000, 32'h1, 8'h01));
    send_req(route_req(MODE_SPARE_5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
    send_req(route_req(MODE_SPARE_6, 32'h0000_0000, 32'h0000_0000, 32'h0, 8'h00));
    send_req(route_req(MODE_SPARE_7, 32'hA5A5_5A5A, 32'hFFFF_0000, 32'h1234, 8'h5A));
    send_req(route_req(srt_pkg::MODE_ADD, 32'h0000_0000, 32'h0000_0000, 32'hAAAA_AAAA, 8'hFF));
    send_req(route_req(srt_pkg::MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 8'h00));
    send_req(route_req(srt_pkg::MODE_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 8'h11));
    send_req(route_req(srt_pkg::MODE_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'hDEAD_BEEF, 8'h22));
    send_req(route_req(srt_pkg::MODE_ADD, 32'h0A00_0000, 32'hFFFF_0000, 32'h0A00_0101, 8'h33));
    send_req(route_req(srt_pkg::MODE_ADD, 32'h0A00_00FF, 32'hFF00_0000, 32'h0A00_0202, 8'h44));
    send_req(route_req(srt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h00));
    send_req(route_req(srt_pkg::MODE_LOOKUP, 32'h0A00_1234, 32'h0, 32'h0, 8'h00));
    send_req(route_req(srt_pkg::MODE_LOOKUP, 32'h0A12_3456, 32'h0, 32'h0, 8'h00));
    send_req(route_req(srt_pkg::MODE_LOOKUP, 32'h0B00_0000, 32'h0, 32'h0, 8'h00));
    send_req(route_req(srt_pkg::MODE_CHANGE, 32'h0A00_0000, 32'hFF00_0000, 32'hC0A8_0001,
                       8'h80));
    send_req(route_req(srt_pkg::MODE_LOOKUP, 32'h0A12_3456, 32'h0, 32'h0, 8'h00));
    send_req(route_req(srt_pkg::MODE_DELETE, 32'h0000_0000, 32'h0000_0000, 32'h0, 8'h00));
    send_req(route_req(srt_pkg::MODE_LOOKUP, 32'h0B00_0000, 32'h0, 32'h0, 8'h00));
    send_req(route_req(srt_pkg::MODE_DELETE, 32'h0A00_00FF, 32'hFF00_0000, 32'h0, 8'h00));
    send_req(route_req(srt_pkg::MODE_ADD, 32'h0012_0034, 32'h00FF_00FF, 32'h7777_7777, 8'h7E));
    send_req(route_req(srt_pkg::MODE_FLUSH,  32'h0, 32'h0, 32'h0, 8'h00));
    send_req(route_req(srt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'h00));
    drain_responses();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      // Routes of one episode share a base so that prefixes overlap and shadow each other.
      base = $urandom;
      for (int unsigned i = 0; i < POOL_SIZE; i++) begin
        plen = $urandom_range(0, 32);
        if ($urandom_range(0, 7) == 0) pool_mask[i] = $urandom;
        else if (plen == 0) pool_mask[i] = 32'h0;
        else pool_mask[i] = 32'hFFFF_FFFF << (32 - plen);
        pool_net[i] = base ^ (32'($urandom_range(0, 15)) << $urandom_range(0, 28));
        if ($urandom_range(0, 9) != 0) pool_net[i] = pool_net[i] & pool_mask[i];
      end
      // Fill episodes drive the table to full and beyond.
      if ($urandom_range(0, 1) == 1) begin
        w_add = 50; w_look = 30; w_del = 6; w_chg = 8; w_flush = 0;
      end else begin
        w_add = 22; w_look = 40; w_del = 13; w_chg = 12; w_flush = 3;
      end
      ep_len = $urandom_range(30, 80);
      for (int unsigned k = 0; k < ep_len && sent < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        p    = $urandom_range(0, POOL_SIZE - 1);
        if (roll < w_add) begin
          r = route_req(srt_pkg::MODE_ADD, pool_net[p], pool_mask[p], $urandom, 8'($urandom));
        end else if (roll < w_add + w_look) begin
          addr = (pool_net[p] & pool_mask[p]) | ($urandom & ~pool_mask[p]);
          if ($urandom_range(0, 7) == 0) addr = $urandom;
          r = route_req(srt_pkg::MODE_LOOKUP, addr, $urandom, $urandom, 8'($urandom));
        end else if (roll < w_add + w_look + w_del) begin
          r = route_req(srt_pkg::MODE_DELETE, pool_net[p], pool_mask[p], $urandom,
                        8'($urandom));
        end else if (roll < w_add + w_look + w_del + w_chg) begin
          r = route_req(srt_pkg::MODE_CHANGE, pool_net[p], pool_mask[p], $urandom,
                        8'($urandom));
        end else if (roll < w_add + w_look + w_del + w_chg + w_flush) begin
          r = route_req(srt_pkg::MODE_FLUSH, $urandom, $urandom, $urandom, 8'($urandom));
        end else begin
          r = route_req(srt_pkg::mode_t'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                        8'($urandom));
        end
        send_req(r);
        sent++;
      end
      if ($urandom_range(0, 2) == 0) drain_responses();
    end

    drain_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
